/* rtl/i2c_master_register_access_assert.svh */
// assertion macros for the i2c register access sequencer
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// checked only while out of reset
`define I2CMRA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2cmra check failed");

// checked on every edge, reset included
`define I2CMRA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("i2cmra check failed");

`endif

/* rtl/i2cmra_pkg.sv */
`timescale 1ns / 1ps

package i2cmra_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic [3:0] PH_IDLE        = 4'd15;
    localparam logic [7:0] ACK_LIMIT_INIT = 8'd10;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_BURST = 2'd2;
    localparam logic [1:0] REQ_BAD   = 2'd3;

    typedef enum logic [2:0] {
        K_START,
        K_SEND,
        K_ACK,
        K_READ,
        K_STOP,
        K_NONE
    } kind_t;

    typedef struct packed {
        logic [3:0] phase;
        logic [1:0] slot;
        logic [3:0] bit_idx;
        logic [7:0] shift;
        logic [7:0] bytes_left;
        logic [7:0] ack_cnt;
        logic [1:0] rtype;
        logic [7:0] dev;
        logic [7:0] reg_addr;
        logic [7:0] wdata;
        logic       scl;
        logic       sda;
        logic       oe;
    } seq_state_t;

    function automatic kind_t kind_of(logic [3:0] ph, logic [1:0] rtype);
        kind_t k;
        k = K_NONE;
        if (ph != PH_IDLE) begin
            if (rtype == REQ_WRITE) begin
                unique case (ph)
                    4'd0:                      k = K_START;
                    4'd1, 4'd3, 4'd5:          k = K_SEND;
                    4'd2, 4'd4, 4'd6:          k = K_ACK;
                    4'd7:                      k = K_STOP;
                    default:                   k = K_NONE;
                endcase
            end
            else begin
                unique case (ph)
                    4'd0, 4'd5:                k = K_START;
                    4'd1, 4'd3, 4'd6:          k = K_SEND;
                    4'd2, 4'd4, 4'd7:          k = K_ACK;
                    4'd8:                      k = K_READ;
                    4'd9:                      k = K_STOP;
                    default:                   k = K_NONE;
                endcase
            end
        end
        return k;
    endfunction

    function automatic logic [7:0] byte_to_send(seq_state_t s);
        logic [7:0] b;
        unique case (s.phase)
            4'd1:    b = s.dev;
            4'd3:    b = s.reg_addr;
            4'd5:    b = s.wdata;
            4'd6:    b = s.dev + 8'd1;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic seq_state_t enter_element(seq_state_t s_in);
        seq_state_t s;
        kind_t      k;
        s         = s_in;
        s.slot    = 2'd0;
        s.bit_idx = 4'd0;
        s.ack_cnt = 8'd0;
        k         = kind_of(s.phase, s.rtype);
        if (k == K_NONE) begin
            s.phase = PH_IDLE;
        end
        else if (k == K_SEND) begin
            s.shift = byte_to_send(s);
        end
        else if (k == K_READ) begin
            s.shift = 8'd0;
            if (s.bytes_left == 8'd0) begin
                s.phase = s.phase + 4'd1;
                if (kind_of(s.phase, s.rtype) == K_NONE) begin
                    s.phase = PH_IDLE;
                end
            end
        end
        return s;
    endfunction

endpackage

/* rtl/i2c_master_register_access.sv */
`timescale 1ns / 1ps
// a transaction accepted into the input register is processed and offered on m_tdata from the output register
// throughput: one request and one result per cycle, stalled only by m_tready
// the sequencer state is updated in the same cycle as the result register
// reset: pipeline empty, bus idle with scl and sda released high and driven,
// ack wait limit back to 10
module i2c_master_register_access
    import i2cmra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // req_valid, device_addr, reg_addr, write_data, read_count, sda_sample, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // scl, sda_out, sda_is_output, busy_res, byte_valid, byte_data, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // byte_last
    output logic                 m_tlast
);

    // idle phase, all counters and request fields clear, scl, sda and oe high
    localparam seq_state_t SEQ_RESET = {PH_IDLE, 56'd0, 3'b111};

    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [1:0]           in_type_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_last_reg;
    logic [7:0]           ack_limit_reg;
    seq_state_t           st_reg;
    seq_state_t           st_next;
    logic [M_TDATA_W-1:0] out_data_next;
    logic                 out_last_next;
    logic                 out_free;
    logic                 step;

    logic                 req_valid;
    logic [7:0]           device_addr;
    logic [7:0]           reg_addr;
    logic [7:0]           write_data;
    logic [7:0]           read_count;
    logic                 sda_sample;

    logic                 busy;
    logic                 bvalid;
    logic [7:0]           bdata;
    logic                 blast;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign req_valid   = in_data_reg[0];
    assign device_addr = in_data_reg[8:1];
    assign reg_addr    = in_data_reg[16:9];
    assign write_data  = in_data_reg[24:17];
    assign read_count  = in_data_reg[32:25];
    assign sda_sample  = in_data_reg[33];

    always_comb
    begin
        st_next = st_reg;
        busy    = 1'b0;
        bvalid  = 1'b0;
        bdata   = 8'd0;
        blast   = 1'b0;

        if (st_next.phase == PH_IDLE && req_valid && in_type_reg != REQ_BAD)
        begin
            st_next.rtype    = in_type_reg;
            st_next.dev      = device_addr;
            st_next.reg_addr = reg_addr;
            st_next.wdata    = write_data;
            if (in_type_reg == REQ_READ)
            begin
                st_next.bytes_left = 8'd1;
            end
            else if (in_type_reg == REQ_BURST)
            begin
                st_next.bytes_left = read_count;
            end
            else
            begin
                st_next.bytes_left = 8'd0;
            end
            st_next.phase = 4'd0;
            st_next       = enter_element(st_next);
        end

        if (st_next.phase != PH_IDLE)
        begin
            busy = 1'b1;
            unique case (kind_of(st_next.phase, st_next.rtype))
                K_START:
                begin
                    if (st_next.slot == 2'd0)
                    begin
                        st_next.oe   = 1'b1;
                        st_next.sda  = 1'b1;
                        st_next.scl  = 1'b1;
                        st_next.slot = 2'd1;
                    end
                    else
                    begin
                        st_next.sda   = 1'b0;
                        st_next.phase = st_next.phase + 4'd1;
                        st_next       = enter_element(st_next);
                    end
                end
                K_SEND:
                begin
                    if (st_next.slot == 2'd0)
                    begin
                        st_next.oe   = 1'b1;
                        st_next.scl  = 1'b0;
                        st_next.slot = 2'd1;
                    end
                    else if (st_next.slot == 2'd1)
                    begin
                        st_next.sda   = st_next.shift[7];
                        st_next.shift = {st_next.shift[6:0], 1'b0};
                        st_next.slot  = 2'd2;
                    end
                    else
                    begin
                        st_next.scl     = 1'b1;
                        st_next.slot    = 2'd0;
                        st_next.bit_idx = st_next.bit_idx + 4'd1;
                        if (st_next.bit_idx >= 4'd8)
                        begin
                            st_next.phase = st_next.phase + 4'd1;
                            st_next       = enter_element(st_next);
                        end
                    end
                end
                K_ACK:
                begin
                    if (st_next.slot == 2'd0)
                    begin
                        st_next.oe   = 1'b0;
                        st_next.scl  = 1'b1;
                        st_next.slot = (sda_sample && ack_limit_reg != 8'd0) ? 2'd1 : 2'd2;
                    end
                    else if (st_next.slot == 2'd1)
                    begin
                        st_next.scl     = 1'b1;
                        st_next.ack_cnt = st_next.ack_cnt + 8'd1;
                        if (!sda_sample || st_next.ack_cnt >= ack_limit_reg)
                        begin
                            st_next.slot = 2'd2;
                        end
                    end
                    else
                    begin
                        st_next.scl   = 1'b0;
                        st_next.phase = st_next.phase + 4'd1;
                        st_next       = enter_element(st_next);
                    end
                end
                K_READ:
                begin
                    if (st_next.bit_idx < 4'd8)
                    begin
                        if (st_next.slot == 2'd0)
                        begin
                            st_next.oe   = 1'b0;
                            st_next.scl  = 1'b0;
                            st_next.slot = 2'd1;
                        end
                        else
                        begin
                            st_next.scl     = 1'b1;
                            st_next.shift   = {st_next.shift[6:0], sda_sample};
                            st_next.slot    = 2'd0;
                            st_next.bit_idx = st_next.bit_idx + 4'd1;
                            if (st_next.bit_idx == 4'd8)
                            begin
                                bvalid = 1'b1;
                                bdata  = st_next.shift;
                                blast  = (st_next.bytes_left == 8'd1);
                            end
                        end
                    end
                    else
                    begin
                        if (st_next.slot == 2'd0)
                        begin
                            st_next.oe   = 1'b1;
                            st_next.scl  = 1'b0;
                            st_next.slot = 2'd1;
                        end
                        else if (st_next.slot == 2'd1)
                        begin
                            st_next.sda  = (st_next.bytes_left == 8'd1);
                            st_next.slot = 2'd2;
                        end
                        else if (st_next.slot == 2'd2)
                        begin
                            st_next.scl  = 1'b1;
                            st_next.slot = 2'd3;
                        end
                        else
                        begin
                            st_next.scl        = 1'b0;
                            st_next.bytes_left = st_next.bytes_left - 8'd1;
                            if (st_next.bytes_left == 8'd0)
                            begin
                                st_next.phase = st_next.phase + 4'd1;
                                st_next       = enter_element(st_next);
                            end
                            else
                            begin
                                st_next.bit_idx = 4'd0;
                                st_next.slot    = 2'd0;
                                st_next.shift   = 8'd0;
                            end
                        end
                    end
                end
                K_STOP:
                begin
                    if (st_next.slot == 2'd0)
                    begin
                        st_next.oe   = 1'b1;
                        st_next.scl  = 1'b0;
                        st_next.slot = 2'd1;
                    end
                    else if (st_next.slot == 2'd1)
                    begin
                        st_next.sda  = 1'b0;
                        st_next.slot = 2'd2;
                    end
                    else if (st_next.slot == 2'd2)
                    begin
                        st_next.scl  = 1'b1;
                        st_next.slot = 2'd3;
                    end
                    else
                    begin
                        st_next.sda   = 1'b1;
                        st_next.phase = st_next.phase + 4'd1;
                        st_next       = enter_element(st_next);
                    end
                end
                default:
                begin
                    st_next.phase = PH_IDLE;
                end
            endcase
        end

        out_data_next = {3'd0, bdata, bvalid, busy, st_next.oe, st_next.sda, st_next.scl};
        out_last_next = blast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_data_reg   <= '0;
            in_type_reg   <= REQ_WRITE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            ack_limit_reg <= ACK_LIMIT_INIT;
            st_reg        <= SEQ_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ack_limit_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (s_tvalid && s_tready)
            begin
                in_data_reg <= s_tdata;
                in_type_reg <= s_tuser;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                st_reg       <= st_next;
                out_data_reg <= out_data_next;
                out_last_reg <= out_last_next;
            end
        end
    end

endmodule

/* rtl/i2cmra_checker.sv */
`timescale 1ns / 1ps
`include "i2c_master_register_access_assert.svh"

module i2cmra_checker
    import i2cmra_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // no result is offered while reset is held
    `I2CMRA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !m_tvalid)

    // a stalled transaction stays offered
    `I2CMRA_ASSERT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid)

    // idle bus has both lines high and sda driven
    `I2CMRA_ASSERT(a_idle_pins, clk, rst_n, m_tvalid && !m_tdata[3] |-> m_tdata[2:0] == 3'b111)

    // a read byte only comes out during a transaction, and tlast only with a byte
    `I2CMRA_ASSERT(a_byte_busy, clk, rst_n, m_tvalid && m_tdata[4] |-> m_tdata[3])
    `I2CMRA_ASSERT(a_no_byte, clk, rst_n, m_tvalid && !m_tdata[4] |-> m_tdata[12:5] == 8'd0 && !m_tlast)

endmodule

bind i2c_master_register_access i2cmra_checker u_i2cmra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* verif/i2c_bus_checker.sv */
`timescale 1ns / 1ps
module i2c_bus_checker
    import i2cmra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // req_valid, device_addr, reg_addr, write_data, read_count, sda_sample, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // scl, sda_out, sda_is_output, busy_res, byte_valid, byte_data, zero pad
    input  logic [M_TDATA_W-1:0] m_tdata,
    // byte_last
    input  logic                 m_tlast,
    output int                   mismatches,
    output int                   pending,
    output logic                 seq_idle
);

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       oe;
        logic       busy;
        logic       bvalid;
        logic [7:0] bdata;
        logic       blast;
    } bus_sample_t;

    bus_sample_t pin_forecast_q[$];
    bus_sample_t fresh;
    bus_sample_t seen;
    int          result_no;

    logic [3:0] phase;
    logic [1:0] slot;
    logic [3:0] bit_no;
    logic [7:0] shreg;
    logic [7:0] bytes_left;
    logic [7:0] ack_ticks;
    logic [7:0] ack_limit;
    logic [1:0] req_kind;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_byte;
    logic       scl;
    logic       sda;
    logic       sda_oe;

    function automatic kind_t step_kind(logic [3:0] ph, logic [1:0] rk);
        kind_t k;
        k = K_NONE;
        if (ph == PH_IDLE)
        begin
            k = K_NONE;
        end
        else if (rk == REQ_WRITE)
        begin
            case (ph)
                4'd0:             k = K_START;
                4'd1, 4'd3, 4'd5: k = K_SEND;
                4'd2, 4'd4, 4'd6: k = K_ACK;
                4'd7:             k = K_STOP;
                default:          k = K_NONE;
            endcase
        end
        else
        begin
            case (ph)
                4'd0, 4'd5:       k = K_START;
                4'd1, 4'd3, 4'd6: k = K_SEND;
                4'd2, 4'd4, 4'd7: k = K_ACK;
                4'd8:             k = K_READ;
                4'd9:             k = K_STOP;
                default:          k = K_NONE;
            endcase
        end
        return k;
    endfunction

    function automatic logic [7:0] outgoing_byte();
        logic [7:0] b;
        case (phase)
            4'd1:    b = dev_addr;
            4'd3:    b = reg_addr;
            4'd5:    b = wr_byte;
            4'd6:    b = dev_addr + 8'd1;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    task automatic enter_step();
        kind_t k;
        slot      = 2'd0;
        bit_no    = 4'd0;
        ack_ticks = 8'd0;
        k         = step_kind(phase, req_kind);
        if (k == K_SEND)
        begin
            shreg = outgoing_byte();
        end
        else if (k == K_READ)
        begin
            shreg = 8'd0;
            // burst of zero bytes goes straight on to the stop
            if (bytes_left == 8'd0)
            begin
                phase = phase + 4'd1;
                k     = step_kind(phase, req_kind);
            end
        end
        if (k == K_NONE)
            phase = PH_IDLE;
    endtask

    task automatic next_step();
        phase = phase + 4'd1;
        enter_step();
    endtask

    task automatic play_bus_tick(input logic [S_TDATA_W-1:0] d, input logic [1:0] rk,
                                 output bus_sample_t e);
        logic smp;
        smp = d[33];
        e   = '0;
        if (phase == PH_IDLE && d[0] && rk != REQ_BAD)
        begin
            req_kind   = rk;
            dev_addr   = d[8:1];
            reg_addr   = d[16:9];
            wr_byte    = d[24:17];
            bytes_left = (rk == REQ_READ) ? 8'd1 : ((rk == REQ_BURST) ? d[32:25] : 8'd0);
            phase      = 4'd0;
            enter_step();
        end
        if (phase != PH_IDLE)
        begin
            e.busy = 1'b1;
            case (step_kind(phase, req_kind))
                K_START:
                begin
                    if (slot == 2'd0)
                    begin
                        sda_oe = 1'b1;
                        sda    = 1'b1;
                        scl    = 1'b1;
                        slot   = 2'd1;
                    end
                    else
                    begin
                        sda = 1'b0;
                        next_step();
                    end
                end
                K_SEND:
                begin
                    if (slot == 2'd0)
                    begin
                        sda_oe = 1'b1;
                        scl    = 1'b0;
                        slot   = 2'd1;
                    end
                    else if (slot == 2'd1)
                    begin
                        sda   = shreg[7];
                        shreg = {shreg[6:0], 1'b0};
                        slot  = 2'd2;
                    end
                    else
                    begin
                        scl    = 1'b1;
                        slot   = 2'd0;
                        bit_no = bit_no + 4'd1;
                        if (bit_no >= 4'd8)
                            next_step();
                    end
                end
                K_ACK:
                begin
                    if (slot == 2'd0)
                    begin
                        sda_oe = 1'b0;
                        scl    = 1'b1;
                        slot   = (smp && ack_limit != 8'd0) ? 2'd1 : 2'd2;
                    end
                    else if (slot == 2'd1)
                    begin
                        scl       = 1'b1;
                        ack_ticks = ack_ticks + 8'd1;
                        if (!smp || ack_ticks >= ack_limit)
                            slot = 2'd2;
                    end
                    else
                    begin
                        scl = 1'b0;
                        next_step();
                    end
                end
                K_READ:
                begin
                    if (bit_no < 4'd8)
                    begin
                        if (slot == 2'd0)
                        begin
                            sda_oe = 1'b0;
                            scl    = 1'b0;
                            slot   = 2'd1;
                        end
                        else
                        begin
                            scl    = 1'b1;
                            shreg  = {shreg[6:0], smp};
                            slot   = 2'd0;
                            bit_no = bit_no + 4'd1;
                            if (bit_no == 4'd8)
                            begin
                                e.bvalid = 1'b1;
                                e.bdata  = shreg;
                                e.blast  = (bytes_left == 8'd1);
                            end
                        end
                    end
                    else
                    begin
                        case (slot)
                            2'd0:
                            begin
                                sda_oe = 1'b1;
                                scl    = 1'b0;
                                slot   = 2'd1;
                            end
                            2'd1:
                            begin
                                // nack on the last byte, ack otherwise
                                sda  = (bytes_left == 8'd1);
                                slot = 2'd2;
                            end
                            2'd2:
                            begin
                                scl  = 1'b1;
                                slot = 2'd3;
                            end
                            default:
                            begin
                                scl        = 1'b0;
                                bytes_left = bytes_left - 8'd1;
                                if (bytes_left == 8'd0)
                                begin
                                    next_step();
                                end
                                else
                                begin
                                    bit_no = 4'd0;
                                    slot   = 2'd0;
                                    shreg  = 8'd0;
                                end
                            end
                        endcase
                    end
                end
                K_STOP:
                begin
                    case (slot)
                        2'd0:
                        begin
                            sda_oe = 1'b1;
                            scl    = 1'b0;
                            slot   = 2'd1;
                        end
                        2'd1:
                        begin
                            sda  = 1'b0;
                            slot = 2'd2;
                        end
                        2'd2:
                        begin
                            scl  = 1'b1;
                            slot = 2'd3;
                        end
                        default:
                        begin
                            sda = 1'b1;
                            next_step();
                        end
                    endcase
                end
                default:
                begin
                    phase = PH_IDLE;
                end
            endcase
        end
        e.scl = scl;
        e.sda = sda;
        e.oe  = sda_oe;
    endtask

    task automatic compare_field(input string label, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("result %0d: %s expected %0h, got %0h", result_no, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_forecast_q.delete();
            mismatches = 0;
            result_no  = 0;
            phase      = PH_IDLE;
            slot       = 2'd0;
            bit_no     = 4'd0;
            shreg      = 8'd0;
            bytes_left = 8'd0;
            ack_ticks  = 8'd0;
            ack_limit  = ACK_LIMIT_INIT;
            req_kind   = REQ_WRITE;
            dev_addr   = 8'd0;
            reg_addr   = 8'd0;
            wr_byte    = 8'd0;
            scl        = 1'b1;
            sda        = 1'b1;
            sda_oe     = 1'b1;
            pending   <= 0;
            seq_idle  <= 1'b1;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                play_bus_tick(s_tdata, s_tuser, fresh);
                pin_forecast_q.push_back(fresh);
            end
            if (m_tvalid && m_tready)
            begin
                seen.scl    = m_tdata[0];
                seen.sda    = m_tdata[1];
                seen.oe     = m_tdata[2];
                seen.busy   = m_tdata[3];
                seen.bvalid = m_tdata[4];
                seen.bdata  = m_tdata[12:5];
                seen.blast  = m_tlast;
                if (pin_forecast_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("result %0d: unexpected transaction %h", result_no, m_tdata);
                    mismatches++;
                end
                else
                begin
                    fresh = pin_forecast_q.pop_front();
                    compare_field("scl", 8'(fresh.scl), 8'(seen.scl));
                    compare_field("sda_out", 8'(fresh.sda), 8'(seen.sda));
                    compare_field("sda_is_output", 8'(fresh.oe), 8'(seen.oe));
                    compare_field("busy", 8'(fresh.busy), 8'(seen.busy));
                    compare_field("byte_valid", 8'(fresh.bvalid), 8'(seen.bvalid));
                    compare_field("byte_data", fresh.bdata, seen.bdata);
                    compare_field("byte_last", 8'(fresh.blast), 8'(seen.blast));
                end
                result_no++;
            end
            if (cfg_wr_en)
                ack_limit = cfg_wr_data;
            pending  <= pin_forecast_q.size();
            seq_idle <= (phase == PH_IDLE);
        end
    end

endmodule

/* verif/tb_i2c_master_register_access.sv */
`timescale 1ns / 1ps
module tb_i2c_master_register_access;
    import i2cmra_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_TICKS = 200;
    localparam int LONG_HOLD    = 600;

    localparam int SDA_LOW         = 0;
    localparam int SDA_HIGH        = 1;
    localparam int SDA_RAND        = 2;
    localparam int SDA_MOSTLY_HIGH = 3;

    localparam int PACE_BACK_TO_BACK = 0;
    localparam int PACE_RANDOM       = 1;
    localparam int PACE_SPARSE       = 2;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [7:0]           cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    // req_valid, device_addr, reg_addr, write_data, read_count, sda_sample, zero pad
    logic [S_TDATA_W-1:0] s_tdata;
    // req_type
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // scl, sda_out, sda_is_output, busy_res, byte_valid, byte_data, zero pad
    logic [M_TDATA_W-1:0] m_tdata;
    // byte_last
    logic                 m_tlast;

    int   mismatches;
    int   pending;
    logic seq_idle;
    int   cycles = 0;
    int   ticks_sent = 0;
    int   tx_pace = PACE_BACK_TO_BACK;
    int   phase_no;

    i2c_master_register_access dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    i2c_bus_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .pending     (pending),
        .seq_idle    (seq_idle)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_i2c_master_register_access failed");
            $finish;
        end
    end

    function automatic int idle_draw(input int pace);
        int n;
        case (pace)
            PACE_BACK_TO_BACK: n = 0;
            PACE_RANDOM:       n = $urandom_range(0, 17);
            default:           n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
        endcase
        return n;
    endfunction

    function automatic logic sda_draw(input int mode);
        logic b;
        case (mode)
            SDA_LOW:  b = 1'b0;
            SDA_HIGH: b = 1'b1;
            SDA_RAND: b = 1'($urandom_range(0, 1));
            default:  b = ($urandom_range(0, 9) != 0);
        endcase
        return b;
    endfunction

    task automatic send_tick(input logic rv, input logic [1:0] rk, input logic [7:0] dv,
                             input logic [7:0] rg, input logic [7:0] wd,
                             input logic [7:0] cnt, input logic sd);
        int gap;
        logic [S_TDATA_W-1:0] d;
        if (ticks_sent % 64 == 0)
            tx_pace = $urandom_range(PACE_BACK_TO_BACK, PACE_SPARSE);
        gap = idle_draw(tx_pace);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        d        = '0;
        d[0]     = rv;
        d[8:1]   = dv;
        d[16:9]  = rg;
        d[24:17] = wd;
        d[32:25] = cnt;
        d[33]    = sd;
        s_tdata  <= d;
        s_tuser  <= rk;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        ticks_sent++;
    endtask

    // idle ticks until the sequencer is back in idle
    task automatic finish_transfer(input int sda_mode);
        do
            send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), sda_draw(sda_mode));
        while (!seq_idle);
    endtask

    task automatic play(input logic [1:0] rk, input logic [7:0] dv, input logic [7:0] rg,
                        input logic [7:0] wd, input logic [7:0] cnt, input int sda_mode);
        send_tick(1'b1, rk, dv, rg, wd, cnt, sda_draw(sda_mode));
        finish_transfer(sda_mode);
    endtask

    task automatic set_ack_limit(input logic [7:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_ticks(input int n);
        int         k;
        int         sda_mode;
        logic       rv;
        logic [1:0] rk;
        logic [7:0] cnt;
        sda_mode = SDA_RAND;
        for (k = 0; k < n; k++)
        begin
            if (k % 24 == 0)
                sda_mode = $urandom_range(SDA_LOW, SDA_MOSTLY_HIGH);
            rv  = ($urandom_range(0, 9) < 6);
            rk  = ($urandom_range(0, 11) == 0) ? REQ_BAD : 2'($urandom_range(0, 2));
            cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(0, 3));
            send_tick(rv, rk, 8'($urandom), 8'($urandom), 8'($urandom), cnt,
                      sda_draw(sda_mode));
        end
        finish_transfer(SDA_RAND);
    endtask

    // receiver side with two long hold-offs to back the block up
    initial
    begin : result_sink
        int stall;
        int taken;
        int pace;
        m_tready = 1'b0;
        taken    = 0;
        pace     = PACE_BACK_TO_BACK;
        wait (rst_n);
        forever
        begin
            if (taken % 64 == 0)
                pace = $urandom_range(PACE_BACK_TO_BACK, PACE_SPARSE);
            if (taken == 300 || taken == 900)
                stall = LONG_HOLD;
            else
                stall = idle_draw(pace);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'd0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_WRITE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset ack wait limit
        send_tick(1'b0, REQ_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        play(REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, SDA_RAND);
        play(REQ_READ, 8'hFF, 8'h5A, 8'hA5, 8'h00, SDA_HIGH);
        play(REQ_BURST, 8'h10, 8'h20, 8'h00, 8'h00, SDA_RAND);
        play(REQ_BURST, 8'h11, 8'h21, 8'h00, 8'h01, SDA_RAND);
        play(REQ_BURST, 8'h12, 8'h22, 8'h00, 8'h03, SDA_MOSTLY_HIGH);
        play(REQ_BAD, 8'h44, 8'h55, 8'h66, 8'h07, SDA_RAND);
        // second request lands while the first is running
        send_tick(1'b1, REQ_WRITE, 8'hA0, 8'h0F, 8'hF0, 8'h00, 1'b0);
        send_tick(1'b1, REQ_READ, 8'h3C, 8'hC3, 8'h99, 8'h02, 1'b0);
        finish_transfer(SDA_RAND);

        set_ack_limit(8'd0);
        play(REQ_WRITE, 8'h5A, 8'hA5, 8'h3C, 8'h00, SDA_HIGH);
        play(REQ_BURST, 8'hA5, 8'h3C, 8'h00, 8'h02, SDA_RAND);

        set_ack_limit(8'd255);
        play(REQ_WRITE, 8'h81, 8'h7E, 8'h18, 8'h00, SDA_RAND);

        for (phase_no = 0; phase_no < 4; phase_no++)
        begin
            if (phase_no == 3)
                set_ack_limit(8'($urandom));
            else
                set_ack_limit(8'($urandom_range(0, 4)));
            random_ticks(RANDOM_TICKS / 4);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_i2c_master_register_access passed");
        else
            $display("tb_i2c_master_register_access failed");
        $finish;
    end

endmodule
